// ===== rtl/core/ugr_pkg.sv =====
// Shared types, constants and the accent table of the glyph rasterizer.
package ugr_pkg;

  localparam int FONT_BYTES       = 8192;
  localparam int FONT_AW          = $clog2(FONT_BYTES);
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int MAX_GLYPH_WIDTH  = 16;

  localparam logic [7:0] CODE_END     = 8'd0;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_PRINT   = 8'd32;

  // configuration register indexes
  localparam logic [2:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DIRECTION    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd4;

  // text direction codes
  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_90  = 2'd1;
  localparam logic [1:0] DIR_180 = 2'd2;
  localparam logic [1:0] DIR_270 = 2'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] text_byte;
    logic [FONT_AW-1:0] font_addr;
    logic [7:0] font_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [4:0]  row_index;
    logic [4:0]  glyph_width;
    logic [15:0] row_bits;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  cell_width;
    logic [5:0]  glyph_height;
    logic [1:0]  direction;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } cfg_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_END     = 2'd1,
    ACT_NEWLINE = 2'd2,
    ACT_GLYPH   = 2'd3
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] code;
  } dec_t;

  // two-byte accented characters; returns {hit, glyph code}
  function automatic logic [8:0] accent_code(input logic [15:0] pair);
    logic [8:0] r;
    r = 9'd0;
    unique case (pair)
      16'hC381: r = {1'b1, 8'd127};
      16'hC389: r = {1'b1, 8'd128};
      16'hC38D: r = {1'b1, 8'd129};
      16'hC393: r = {1'b1, 8'd130};
      16'hC396: r = {1'b1, 8'd131};
      16'hC590: r = {1'b1, 8'd132};
      16'hC39A: r = {1'b1, 8'd133};
      16'hC39C: r = {1'b1, 8'd134};
      16'hC5B0: r = {1'b1, 8'd135};
      16'hC3A1: r = {1'b1, 8'd136};
      16'hC3A9: r = {1'b1, 8'd137};
      16'hC3AD: r = {1'b1, 8'd138};
      16'hC3B3: r = {1'b1, 8'd139};
      16'hC3B6: r = {1'b1, 8'd140};
      16'hC591: r = {1'b1, 8'd141};
      16'hC3BA: r = {1'b1, 8'd142};
      16'hC3BC: r = {1'b1, 8'd143};
      16'hC5B1: r = {1'b1, 8'd144};
      16'hC2B5: r = {1'b1, 8'd145};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/utf8_text_glyph_rasterizer_unit.sv =====
// Top level of the UTF-8 text glyph rasterizer: registers, decoder, font memory, sequencer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid / in_ready | in_item: func, text, font write
//   out     | output    | out_valid/out_ready | out_item: one glyph row
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Font writes, control bytes and lead bytes leave the sequencer idle. A glyph
// goes through setup (base multiply, width read), then reads each row in the
// states S_RB0, S_RB1 and S_RDAT, paced by the single font memory read port.
// Reset clears the decoder, pen and registers; font memory keeps its contents.
// A stalled out channel holds the sequencer on the current row; a new item is
// taken while the last row still waits in the result register.
module utf8_text_glyph_rasterizer_unit
  import ugr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t               cfg;
  logic               in_take;
  logic               text_take;
  logic               idle;
  dec_t               dec;
  logic               rd_en;
  logic [FONT_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  assign in_ready  = idle;
  assign in_take   = in_valid && in_ready;
  assign text_take = in_take && !in_item.func;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width   <= 5'd8;
      cfg.glyph_height <= 6'd8;
      cfg.direction    <= DIR_0;
      cfg.origin_x     <= 16'd0;
      cfg.origin_y     <= 16'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CELL_WIDTH:   cfg.cell_width   <= cfg_data[4:0];
        REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        REG_DIRECTION:    cfg.direction    <= cfg_data[1:0];
        REG_ORIGIN_X:     cfg.origin_x     <= cfg_data;
        REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  ugr_utf8_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .take      (text_take),
    .text_byte (in_item.text_byte),
    .dec       (dec)
  );

  ugr_font_ram u_font (
    .clk   (clk),
    .we    (in_take && in_item.func),
    .waddr (in_item.font_addr),
    .wdata (in_item.font_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ugr_glyph_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (text_take),
    .dec       (dec),
    .idle      (idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/ugr_font_ram.sv =====
// Font memory: one write port, one registered read port.
module ugr_font_ram
  import ugr_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [FONT_AW-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  logic [FONT_AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [FONT_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ugr_utf8_dec.sv =====
// UTF-8 decoder: lead byte tracking and classification of each text byte.
module ugr_utf8_dec
  import ugr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte,
  output dec_t       dec
);

  logic [7:0] lead_byte;
  logic       lead_pending;
  logic [7:0] lead_byte_next;
  logic       lead_pending_next;
  logic [8:0] hit_code;

  assign hit_code = accent_code({lead_byte, text_byte});

  always_comb begin
    dec.act           = ACT_NONE;
    dec.code          = text_byte;
    lead_byte_next    = 8'd0;
    lead_pending_next = 1'b0;
    if (lead_pending) begin
      // a zero byte never matches, so every miss ends the text
      if (hit_code[8]) begin
        dec.act  = ACT_GLYPH;
        dec.code = hit_code[7:0];
      end else begin
        dec.act = ACT_END;
      end
    end else if (text_byte[7]) begin
      lead_byte_next    = text_byte;
      lead_pending_next = 1'b1;
    end else if (text_byte == CODE_END) begin
      dec.act = ACT_END;
    end else if (text_byte >= CODE_PRINT) begin
      dec.act = ACT_GLYPH;
    end else if (text_byte == CODE_NEWLINE) begin
      dec.act = ACT_NEWLINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte    <= 8'd0;
      lead_pending <= 1'b0;
    end else if (take) begin
      lead_byte    <= lead_byte_next;
      lead_pending <= lead_pending_next;
    end
  end

endmodule

// ===== rtl/core/ugr_glyph_seq.sv =====
// Glyph sequencer: font address generation, row assembly, pen and result register.
module ugr_glyph_seq
  import ugr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               start,
  input  dec_t               dec,
  output logic               idle,
  output logic               rd_en,
  output logic [FONT_AW-1:0] rd_addr,
  input  logic [7:0]         rd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_BASE = 7'b0000010,
    S_WID  = 7'b0000100,
    S_WDAT = 7'b0001000,
    S_RB0  = 7'b0010000,
    S_RB1  = 7'b0100000,
    S_RDAT = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [6:0]         code_off, code_off_next;
  logic [7:0]         size, size_next;
  logic [FONT_AW-1:0] addr, addr_next;
  logic [7:0]         byte0, byte0_next;
  logic [4:0]         width, width_next;
  logic [4:0]         row, row_next;
  logic [15:0]        cursor_x, cursor_x_next;
  logic [15:0]        cursor_y, cursor_y_next;
  logic               out_valid_next;
  out_item_t          out_item_next;

  logic [5:0]  h_eff;
  logic [2:0]  bpr;
  logic [5:0]  cw_sum;
  logic [7:0]  size_prod;
  logic [14:0] base_prod;
  logic [4:0]  w_clamp;
  logic [4:0]  adv_w;
  logic [15:0] adv_x, adv_y;
  logic [15:0] nl_x, nl_y;
  logic [15:0] h_ext;
  logic [7:0]  b0, b1;
  logic [15:0] mask;
  logic        out_free;
  logic        last;

  assign h_eff     = (cfg.glyph_height > 6'(MAX_GLYPH_HEIGHT)) ? 6'(MAX_GLYPH_HEIGHT)
                                                                : cfg.glyph_height;
  assign cw_sum    = {1'b0, cfg.cell_width} + 6'd7;
  assign bpr       = cw_sum[5:3];
  // at most 4 bytes by 32 rows, so the product fits in 8 bits
  assign size_prod = {5'd0, bpr} * {2'd0, h_eff};
  assign base_prod = {8'd0, code_off} * {7'd0, size};
  assign w_clamp   = (rd_data > 8'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : rd_data[4:0];
  assign h_ext     = {10'd0, h_eff};
  assign b0        = (bpr >= 3'd1) ? byte0 : 8'd0;
  assign b1        = (bpr >= 3'd2) ? rd_data : 8'd0;
  assign mask      = ~(16'hFFFF >> width);
  assign out_free  = !out_valid || out_ready;
  assign last      = ({1'b0, row} + 6'd1) == h_eff;
  assign idle      = (state == S_IDLE);

  // pen advance after a glyph; width is known only at the end of the width read
  assign adv_w = (state == S_WDAT) ? w_clamp : width;

  always_comb begin
    adv_x = cursor_x;
    adv_y = cursor_y;
    unique case (cfg.direction)
      DIR_90:  adv_y = cursor_y + {11'd0, adv_w};
      DIR_180: adv_x = cursor_x - {11'd0, adv_w};
      DIR_270: adv_y = cursor_y - {11'd0, adv_w};
      default: adv_x = cursor_x + {11'd0, adv_w};
    endcase
  end

  always_comb begin
    nl_x = cursor_x;
    nl_y = cursor_y;
    unique case (cfg.direction)
      DIR_90: begin
        nl_y = cfg.origin_y;
        nl_x = cursor_x - h_ext;
      end
      DIR_180: begin
        nl_x = cfg.origin_x;
        nl_y = cursor_y - h_ext;
      end
      DIR_270: begin
        nl_y = cfg.origin_y;
        nl_x = cursor_x + h_ext;
      end
      default: begin
        nl_x = cfg.origin_x;
        nl_y = cursor_y + h_ext;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    code_off_next  = code_off;
    size_next      = size;
    addr_next      = addr;
    byte0_next     = byte0;
    width_next     = width;
    row_next       = row;
    cursor_x_next  = cursor_x;
    cursor_y_next  = cursor_y;
    out_valid_next = out_valid && !out_ready;
    out_item_next  = out_item;
    rd_en          = 1'b0;
    rd_addr        = addr;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (dec.act)
            ACT_END: begin
              cursor_x_next = cfg.origin_x;
              cursor_y_next = cfg.origin_y;
            end
            ACT_NEWLINE: begin
              cursor_x_next = nl_x;
              cursor_y_next = nl_y;
            end
            ACT_GLYPH: begin
              code_off_next = 7'(dec.code - CODE_PRINT);
              size_next     = size_prod + 8'd1;
              state_next    = S_BASE;
            end
            default: ;
          endcase
        end
      end
      S_BASE: begin
        addr_next  = FONT_AW'(base_prod + 15'd2);
        state_next = S_WID;
      end
      S_WID: begin
        rd_en      = 1'b1;
        state_next = S_WDAT;
      end
      S_WDAT: begin
        width_next = w_clamp;
        addr_next  = addr + FONT_AW'(1);
        row_next   = 5'd0;
        if (h_eff == 6'd0) begin
          cursor_x_next = adv_x;
          cursor_y_next = adv_y;
          state_next    = S_IDLE;
        end else begin
          state_next = S_RB0;
        end
      end
      S_RB0: begin
        rd_en      = 1'b1;
        state_next = S_RB1;
      end
      S_RB1: begin
        byte0_next = rd_data;
        rd_en      = 1'b1;
        rd_addr    = addr + FONT_AW'(1);
        state_next = S_RDAT;
      end
      S_RDAT: begin
        // second byte stays on the read port until the result register is free
        if (out_free) begin
          out_valid_next            = 1'b1;
          out_item_next.pen_x       = cursor_x;
          out_item_next.pen_y       = cursor_y;
          out_item_next.row_index   = row;
          out_item_next.glyph_width = width;
          out_item_next.row_bits    = {b0, b1} & mask;
          out_item_next.last_row    = last;
          addr_next                 = addr + FONT_AW'(bpr);
          row_next                  = row + 5'd1;
          if (last) begin
            cursor_x_next = adv_x;
            cursor_y_next = adv_y;
            state_next    = S_IDLE;
          end else begin
            state_next = S_RB0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cursor_x  <= 16'd0;
      cursor_y  <= 16'd0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cursor_x  <= cursor_x_next;
      cursor_y  <= cursor_y_next;
    end
  end

  always_ff @(posedge clk) begin
    code_off <= code_off_next;
    size     <= size_next;
    addr     <= addr_next;
    byte0    <= byte0_next;
    width    <= width_next;
    row      <= row_next;
    out_item <= out_item_next;
  end

endmodule
